// ===== rtl/core/a64rel_pkg.sv =====
`timescale 1ns / 1ps
package a64rel_pkg;

  localparam int MAX_INSNS_DEF = 256;

  localparam logic [31:0] LDR_LIT_X  = 32'h5800_0000;
  localparam logic [31:0] B_OP       = 32'h1400_0000;
  localparam logic [31:0] BR_X16     = 32'hD61F_0200;
  localparam logic [31:0] BLR_X16    = 32'hD63F_0200;
  localparam logic [31:0] RET_WORD   = 32'hD65F_03C0;
  localparam logic [31:0] ADR_MASK   = 32'h9F00_0000;
  localparam logic [31:0] LIT_MASK   = 32'h3B00_0000;
  localparam logic [31:0] LIT_MATCH  = 32'h1800_0000;
  localparam logic [31:0] IMM19_KEEP = 32'hFF00_001F;
  localparam logic [31:0] IMM14_KEEP = 32'hFFF8_001F;
  localparam logic [31:0] BL_OP      = 32'h9400_0000;
  localparam logic [31:0] BCOND_OP   = 32'h5400_0000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_IGN   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_EMIT  = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] word;
    logic [63:0] literal;
    logic [7:0]  idx;
  } req_t;

  typedef struct packed {
    logic [63:0] base;
    logic [8:0]  limit;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_LD, S_L_T, S_L_CHK,
    S_P_INIT, S_P_RD, S_P_T, S_P_W,
    S_E_RD, S_E_PC, S_E_T, S_E_IN, S_E_BLD,
    S_OUT
  } bk_state_e;

  function automatic logic is_adr(input logic [31:0] w);
    return (w & ADR_MASK) == 32'h1000_0000;
  endfunction

  function automatic logic is_adrp(input logic [31:0] w);
    return (w & ADR_MASK) == 32'h9000_0000;
  endfunction

  function automatic logic is_b(input logic [31:0] w);
    return (w & 32'hFC00_0000) == B_OP;
  endfunction

  function automatic logic is_bl(input logic [31:0] w);
    return (w & 32'hFC00_0000) == BL_OP;
  endfunction

  function automatic logic is_bc(input logic [31:0] w);
    return (w & 32'hFF00_0010) == BCOND_OP;
  endfunction

  function automatic logic is_cb(input logic [31:0] w);
    return (w & 32'h7E00_0000) == 32'h3400_0000;
  endfunction

  function automatic logic is_tb(input logic [31:0] w);
    return (w & 32'h7E00_0000) == 32'h3600_0000;
  endfunction

  function automatic logic is_lit(input logic [31:0] w);
    return ((w & LIT_MASK) == LIT_MATCH) && (w[31:30] != 2'b11);
  endfunction

  function automatic logic is_cond(input logic [31:0] w);
    return is_bc(w) || is_cb(w) || is_tb(w);
  endfunction

  // byte displacement of a direct branch, zero for anything else
  function automatic logic [63:0] dest_off(input logic [31:0] w);
    logic [63:0] d;
    d = '0;
    if (is_b(w) || is_bl(w)) begin
      d = {{36{w[25]}}, w[25:0], 2'b00};
    end else if (is_bc(w) || is_cb(w)) begin
      d = {{43{w[23]}}, w[23:5], 2'b00};
    end else if (is_tb(w)) begin
      d = {{48{w[18]}}, w[18:5], 2'b00};
    end
    return d;
  endfunction

  function automatic logic [63:0] adr_imm(input logic [31:0] w);
    return {{43{w[23]}}, w[23:5], w[30:29]};
  endfunction

  function automatic logic [2:0] words_for(input logic [31:0] w, input logic internal);
    logic [2:0] n;
    n = 3'd1;
    if (is_adr(w) || is_adrp(w) || is_lit(w)) begin
      n = 3'd4;
    end else if (is_bl(w)) begin
      n = 3'd5;
    end else if (is_b(w)) begin
      n = internal ? 3'd1 : 3'd4;
    end else if (is_cond(w)) begin
      n = internal ? 3'd1 : 3'd5;
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/a64rel_ram.sv =====
`timescale 1ns / 1ps
module a64rel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/a64rel_front.sv =====
`timescale 1ns / 1ps
module a64rel_front import a64rel_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_instruction_word,
  input  logic [63:0] in_literal_value,
  input  logic [7:0]  in_emit_index,
  output logic        q_valid,
  output req_t        q_data,
  input  logic        q_pop
);

  // two-entry request queue
  req_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  req_t       req_in;

  always_comb begin
    case (in_func)
      2'd0:    req_in.cmd = CMD_START;
      2'd1:    req_in.cmd = CMD_LOAD;
      2'd2:    req_in.cmd = CMD_EMIT;
      default: req_in.cmd = CMD_BAD;
    endcase
    req_in.word    = in_instruction_word;
    req_in.literal = in_literal_value;
    req_in.idx     = in_emit_index;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= req_in;
    end
  end

endmodule

// ===== rtl/core/a64rel_back.sv =====
`timescale 1ns / 1ps
module a64rel_back import a64rel_pkg::*; #(
  parameter int MAX_INSNS = MAX_INSNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  req_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word,
  output logic        out_last,
  output logic [1:0]  out_status,
  output logic        extent_done,
  output logic [10:0] clone_size,
  output logic [8:0]  loaded_count
);

  localparam int IW = $clog2(MAX_INSNS);
  localparam int CW = $clog2(MAX_INSNS + 1);
  localparam int TW = $clog2(5 * MAX_INSNS + 1);
  localparam int LW = (CW > 9) ? CW : 9;

  bk_state_e state_r, state_nxt;

  req_t        req_r, req_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        end_r, end_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [31:0] w_r, w_nxt;
  logic [63:0] lit_r, lit_nxt;
  logic [63:0] pc_r, pc_nxt;
  logic [63:0] t_r, t_nxt;
  logic [63:0] fend_r, fend_nxt;
  logic [LW-1:0] lim_r, lim_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [TW-1:0] acc_r, acc_nxt;
  logic [TW-1:0] offi_r, offi_nxt;
  logic        inside_r, inside_nxt;
  logic [31:0] wbuf_r [5];
  logic [31:0] wbuf_nxt [5];
  logic [2:0]  n_r, n_nxt, k_r, k_nxt;
  logic [1:0]  st_r, st_nxt;

  // memory ports
  logic          src_we, off_we;
  logic [IW-1:0] src_waddr, src_raddr, off_waddr, off_raddr;
  logic [31:0]   src_rdata;
  logic [63:0]   lit_rdata;
  logic [TW-1:0] off_wdata, off_rdata;

  // helpers
  logic [IW-1:0] idx_a, load_a, ti;
  logic [IW+1:0] dtl;
  logic          idx_bad, stop, in_win, last_step;
  logic [LW-1:0] lim_clamp;
  logic [TW:0]   acc_sum;
  logic [31:0]   rel, flip, lo_t, hi_t, v_lo, v_hi;
  logic [31:0]   bw [5];
  logic [2:0]    bn;
  logic [63:0]   aimm;

  a64rel_ram #(.WIDTH(32), .DEPTH(MAX_INSNS)) u_src (
    .clk(clk), .we(src_we), .waddr(src_waddr), .wdata(req_r.word),
    .raddr(src_raddr), .rdata(src_rdata)
  );

  a64rel_ram #(.WIDTH(64), .DEPTH(MAX_INSNS)) u_lit (
    .clk(clk), .we(src_we), .waddr(src_waddr), .wdata(req_r.literal),
    .raddr(src_raddr), .rdata(lit_rdata)
  );

  a64rel_ram #(.WIDTH(TW), .DEPTH(MAX_INSNS)) u_off (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_rdata)
  );

  assign idx_a   = IW'(req_r.idx);
  assign idx_bad = ((CW + 8)'(req_r.idx) >= (CW + 8)'(count_r));
  assign load_a  = (count_r >= CW'(MAX_INSNS)) ? IW'(MAX_INSNS - 1) : IW'(count_r);
  assign aimm    = adr_imm(w_r);

  always_comb begin
    if (cfg.limit == 9'd0) begin
      lim_clamp = LW'(1);
    end else if (LW'(cfg.limit) > LW'(MAX_INSNS)) begin
      lim_clamp = LW'(MAX_INSNS);
    end else begin
      lim_clamp = LW'(cfg.limit);
    end
  end

  // B leaving the window ends the scan, as do RET and the limit
  assign stop = (w_r == RET_WORD) || (LW'(count_r) >= lim_r) ||
                (is_b(w_r) && ((t_r < cfg.base) || (t_r >= fend_r)));

  assign in_win    = (t_r >= cfg.base) && (t_r < fend_r);
  assign last_step = ((i_r + CW'(1)) == count_r);
  assign acc_sum   = {1'b0, acc_r} + (TW + 1)'(words_for(w_r, in_win));

  assign dtl = t_r[IW+1:0] - cfg.base[IW+1:0];
  assign ti  = dtl[IW+1:2];

  assign src_we    = (state_r == S_LD);
  assign src_waddr = load_a;
  assign src_raddr = (state_r == S_P_RD) ? i_r[IW-1:0] : idx_a;
  assign off_we    = (state_r == S_P_W);
  assign off_waddr = i_r[IW-1:0];
  assign off_wdata = acc_r;
  assign off_raddr = (state_r == S_E_IN) ? ti : idx_a;

  // clone words of one instruction
  always_comb begin
    rel  = 32'($signed({1'b0, off_rdata}) - $signed({1'b0, offi_r}));
    flip = is_bc(w_r) ? (w_r ^ 32'h0000_0001) : (w_r ^ 32'h0100_0000);
    lo_t = t_r[31:0];
    hi_t = t_r[63:32];
    v_lo = lit_r[31:0];
    v_hi = (w_r[31:30] == 2'b01) ? lit_r[63:32] : 32'd0;
    for (int j = 0; j < 5; j++) begin
      bw[j] = 32'd0;
    end
    bn = 3'd1;
    if (is_adr(w_r) || is_adrp(w_r)) begin
      bw[0] = LDR_LIT_X | 32'h40 | {27'd0, w_r[4:0]};
      bw[1] = B_OP | 32'd3;
      bw[2] = lo_t;
      bw[3] = hi_t;
      bn    = 3'd4;
    end else if (is_lit(w_r)) begin
      bw[0] = (w_r & IMM19_KEEP) | 32'h40;
      bw[1] = B_OP | 32'd3;
      bw[2] = v_lo;
      bw[3] = v_hi;
      bn    = 3'd4;
    end else if (is_bl(w_r)) begin
      bw[0] = LDR_LIT_X | 32'h60 | 32'h10;
      bw[1] = BLR_X16;
      bw[2] = B_OP | 32'd3;
      bw[3] = lo_t;
      bw[4] = hi_t;
      bn    = 3'd5;
    end else if (is_b(w_r) || is_cond(w_r)) begin
      if (inside_r) begin
        if (is_b(w_r)) begin
          bw[0] = B_OP | {6'd0, rel[25:0]};
        end else if (is_tb(w_r)) begin
          bw[0] = (w_r & IMM14_KEEP) | {13'd0, rel[13:0], 5'd0};
        end else begin
          bw[0] = (w_r & IMM19_KEEP) | {8'd0, rel[18:0], 5'd0};
        end
      end else if (is_b(w_r)) begin
        bw[0] = LDR_LIT_X | 32'h40 | 32'h10;
        bw[1] = BR_X16;
        bw[2] = lo_t;
        bw[3] = hi_t;
        bn    = 3'd4;
      end else begin
        // inverted condition skips the far jump
        bw[0] = is_tb(w_r) ? ((flip & IMM14_KEEP) | 32'hA0)
                           : ((flip & IMM19_KEEP) | 32'hA0);
        bw[1] = LDR_LIT_X | 32'h40 | 32'h10;
        bw[2] = BR_X16;
        bw[3] = lo_t;
        bw[4] = hi_t;
        bn    = 3'd5;
      end
    end else begin
      bw[0] = w_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (req_r.cmd)
          CMD_LOAD: state_nxt = end_r ? S_OUT : S_LD;
          CMD_EMIT: state_nxt = (!end_r || idx_bad) ? S_OUT : S_E_RD;
          default:  state_nxt = S_OUT;
        endcase
      end
      S_LD:     state_nxt = S_L_T;
      S_L_T:    state_nxt = S_L_CHK;
      S_L_CHK:  state_nxt = stop ? S_P_INIT : S_OUT;
      S_P_INIT: state_nxt = S_P_RD;
      S_P_RD:   state_nxt = S_P_T;
      S_P_T:    state_nxt = S_P_W;
      S_P_W:    state_nxt = last_step ? S_OUT : S_P_RD;
      S_E_RD:   state_nxt = S_E_PC;
      S_E_PC:   state_nxt = S_E_T;
      S_E_T:    state_nxt = S_E_IN;
      S_E_IN:   state_nxt = S_E_BLD;
      S_E_BLD:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall && (k_r == n_r - 3'd1)) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    req_nxt    = req_r;
    count_nxt  = count_r;
    end_nxt    = end_r;
    total_nxt  = total_r;
    w_nxt      = w_r;
    lit_nxt    = lit_r;
    pc_nxt     = pc_r;
    t_nxt      = t_r;
    fend_nxt   = fend_r;
    lim_nxt    = lim_r;
    i_nxt      = i_r;
    acc_nxt    = acc_r;
    offi_nxt   = offi_r;
    inside_nxt = inside_r;
    wbuf_nxt   = wbuf_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    st_nxt     = st_r;
    q_pop      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          req_nxt = q_data;
          w_nxt   = q_data.word;
        end
      end
      S_DISP: begin
        wbuf_nxt[0] = 32'd0;
        n_nxt       = 3'd1;
        k_nxt       = 3'd0;
        st_nxt      = ST_IGN;
        case (req_r.cmd)
          CMD_START: begin
            count_nxt = '0;
            end_nxt   = 1'b0;
            total_nxt = '0;
            st_nxt    = ST_OK;
          end
          CMD_EMIT: begin
            if (end_r && idx_bad) st_nxt = ST_RANGE;
          end
          default: st_nxt = ST_IGN;
        endcase
      end
      S_LD: begin
        count_nxt = CW'(load_a) + CW'(1);
        pc_nxt    = cfg.base + {{(62 - IW){1'b0}}, load_a, 2'b00};
        lim_nxt   = lim_clamp;
      end
      S_L_T: begin
        t_nxt    = pc_r + dest_off(w_r);
        fend_nxt = cfg.base + {{(62 - LW){1'b0}}, lim_r, 2'b00};
      end
      S_L_CHK: begin
        st_nxt = ST_OK;
      end
      S_P_INIT: begin
        fend_nxt = cfg.base + {{(62 - CW){1'b0}}, count_r, 2'b00};
        i_nxt    = '0;
        pc_nxt   = cfg.base;
        acc_nxt  = '0;
      end
      S_P_T: begin
        w_nxt = src_rdata;
        t_nxt = pc_r + dest_off(src_rdata);
      end
      S_P_W: begin
        acc_nxt = acc_sum[TW-1:0];
        i_nxt   = i_r + CW'(1);
        pc_nxt  = pc_r + 64'd4;
        if (last_step) begin
          total_nxt = acc_sum[TW-1:0];
          end_nxt   = 1'b1;
        end
      end
      S_E_PC: begin
        w_nxt    = src_rdata;
        lit_nxt  = lit_rdata;
        offi_nxt = off_rdata;
        pc_nxt   = cfg.base + {54'd0, req_r.idx, 2'b00};
        fend_nxt = cfg.base + {{(62 - CW){1'b0}}, count_r, 2'b00};
      end
      S_E_T: begin
        if (is_adrp(w_r)) begin
          t_nxt = {pc_r[63:12], 12'd0} + {aimm[51:0], 12'd0};
        end else if (is_adr(w_r)) begin
          t_nxt = pc_r + aimm;
        end else begin
          t_nxt = pc_r + dest_off(w_r);
        end
      end
      S_E_IN: begin
        inside_nxt = in_win;
      end
      S_E_BLD: begin
        wbuf_nxt = bw;
        n_nxt    = bn;
        k_nxt    = 3'd0;
        st_nxt   = ST_OK;
      end
      S_OUT: begin
        if (!out_stall && (k_r != n_r - 3'd1)) k_nxt = k_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      end_r   <= 1'b0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      end_r   <= end_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    w_r      <= w_nxt;
    lit_r    <= lit_nxt;
    pc_r     <= pc_nxt;
    t_r      <= t_nxt;
    fend_r   <= fend_nxt;
    lim_r    <= lim_nxt;
    i_r      <= i_nxt;
    acc_r    <= acc_nxt;
    offi_r   <= offi_nxt;
    inside_r <= inside_nxt;
    wbuf_r   <= wbuf_nxt;
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    st_r     <= st_nxt;
  end

  assign out_valid    = (state_r == S_OUT);
  assign out_word     = wbuf_r[k_r];
  assign out_last     = (k_r == n_r - 3'd1);
  assign out_status   = st_r;
  assign extent_done  = end_r;
  assign clone_size   = 11'(total_r);
  assign loaded_count = 9'(count_r);

endmodule

// ===== rtl/core/aarch64_pc_relative_relocator_core.sv =====
`timescale 1ns / 1ps
// Relocates an AArch64 function into a clone. Start (func 0) clears the block, loads
// (func 1) append one instruction each with its literal value, and the extent ends at
// RET, at a B leaving the source window, or at the configured limit; an offset pass
// over the loaded instructions then runs before the final load's result appears. An
// emit (func 2) returns 1, 4 or 5 words of one instruction: after the store reads and
// the 64-bit target arithmetic it hands out its words in order, holding while
// out_stall is high. A two-request queue takes new requests, until it is full, while
// the sequencer works or its output waits.
module aarch64_pc_relative_relocator_core import a64rel_pkg::*; #(
  parameter int MAX_INSNS = MAX_INSNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_instruction_word,
  input  logic [63:0] in_literal_value,
  input  logic [7:0]  in_emit_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_output_word,
  output logic        out_last_word,
  output logic [1:0]  out_status,
  output logic        out_extent_done,
  output logic [10:0] out_clone_size,
  output logic [8:0]  out_loaded_count
);

  cfg_t cfg_r, cfg_nxt;
  logic q_valid, q_pop;
  req_t q_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:  cfg_nxt.base  = cfg_wdata;
        CFG_LIMIT: cfg_nxt.limit = cfg_wdata[8:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base  <= 64'd0;
      cfg_r.limit <= 9'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  a64rel_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_instruction_word(in_instruction_word), .in_literal_value(in_literal_value),
    .in_emit_index(in_emit_index),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  a64rel_back #(.MAX_INSNS(MAX_INSNS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_output_word), .out_last(out_last_word), .out_status(out_status),
    .extent_done(out_extent_done), .clone_size(out_clone_size),
    .loaded_count(out_loaded_count)
  );

endmodule

// ===== tb/relocator_checker.sv =====
`timescale 1ns / 1ps
module relocator_checker import a64rel_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_instruction_word,
  input  logic [63:0] in_literal_value,
  input  logic [7:0]  in_emit_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_output_word,
  input  logic        out_last_word,
  input  logic [1:0]  out_status,
  input  logic        out_extent_done,
  input  logic [10:0] out_clone_size,
  input  logic [8:0]  out_loaded_count,
  output int          errors,
  output int          pending
);

  localparam int DEPTH = 256;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic [1:0]  st;
    logic        done;
    logic [10:0] size;
    logic [8:0]  count;
  } clone_word_t;

  clone_word_t clone_q[$];

  logic [31:0] src_words[DEPTH];
  logic [63:0] lit_values[DEPTH];
  logic [10:0] clone_offs[DEPTH];
  int unsigned n_loaded;
  bit          extent_end;
  logic [10:0] clone_total;
  logic [63:0] base_addr;
  logic [8:0]  limit_reg;

  function automatic logic [63:0] sext(input logic [63:0] v, input int bits);
    logic [63:0] s;
    s = v << (64 - bits);
    return $signed(s) >>> (64 - bits);
  endfunction

  function automatic bit op_adr(input logic [31:0] w);
    return (w & 32'h9F00_0000) == 32'h1000_0000;
  endfunction
  function automatic bit op_adrp(input logic [31:0] w);
    return (w & 32'h9F00_0000) == 32'h9000_0000;
  endfunction
  function automatic bit op_b(input logic [31:0] w);
    return w[31:26] == 6'b000101;
  endfunction
  function automatic bit op_bl(input logic [31:0] w);
    return w[31:26] == 6'b100101;
  endfunction
  function automatic bit op_bcond(input logic [31:0] w);
    return w[31:24] == 8'h54 && !w[4];
  endfunction
  function automatic bit op_cbz(input logic [31:0] w);
    return w[30:25] == 6'b011010;
  endfunction
  function automatic bit op_tbz(input logic [31:0] w);
    return w[30:25] == 6'b011011;
  endfunction
  function automatic bit op_lit(input logic [31:0] w);
    return w[29:27] == 3'b011 && w[25:24] == 2'b00 && w[31:30] != 2'b11;
  endfunction
  function automatic bit op_cond(input logic [31:0] w);
    return op_bcond(w) || op_cbz(w) || op_tbz(w);
  endfunction

  function automatic logic [63:0] branch_disp(input logic [31:0] w);
    if (op_b(w) || op_bl(w)) return sext({38'b0, w[25:0]}, 26) << 2;
    if (op_bcond(w) || op_cbz(w)) return sext({45'b0, w[23:5]}, 19) << 2;
    if (op_tbz(w)) return sext({50'b0, w[18:5]}, 14) << 2;
    return '0;
  endfunction

  function automatic int unsigned eff_limit();
    if (limit_reg == 0) return 1;
    if (limit_reg > DEPTH) return DEPTH;
    return limit_reg;
  endfunction

  function automatic bit in_extent(input logic [63:0] t, input logic [63:0] fend);
    return t >= base_addr && t < fend;
  endfunction

  function automatic int unsigned clone_len(input logic [31:0] w, input logic [63:0] pc,
                                            input logic [63:0] fend);
    if (op_adr(w) || op_adrp(w) || op_lit(w)) return 4;
    if (op_bl(w)) return 5;
    if (op_b(w)) return in_extent(pc + branch_disp(w), fend) ? 1 : 4;
    if (op_cond(w)) return in_extent(pc + branch_disp(w), fend) ? 1 : 5;
    return 1;
  endfunction

  task automatic lay_out_clone();
    logic [63:0] fend;
    logic [10:0] acc;
    fend = base_addr + 64'(n_loaded) * 4;
    acc = '0;
    for (int i = 0; i < n_loaded; i++) begin
      clone_offs[i] = acc;
      acc += 11'(clone_len(src_words[i], base_addr + 64'(i) * 4, fend));
    end
    clone_total = acc;
    extent_end = 1'b1;
  endtask

  task automatic push_word(input logic [31:0] w, input bit last, input logic [1:0] st);
    clone_q.push_back('{word: w, last: last, st: st, done: extent_end,
                        size: clone_total, count: 9'(n_loaded)});
  endtask

  task automatic push_far(ref logic [31:0] ws[$], input logic [63:0] t, input bit link);
    if (link) begin
      ws.push_back(LDR_LIT_X | (32'd3 << 5) | 32'd16);
      ws.push_back(BLR_X16);
      ws.push_back(B_OP | 32'd3);
    end else begin
      ws.push_back(LDR_LIT_X | (32'd2 << 5) | 32'd16);
      ws.push_back(BR_X16);
    end
    ws.push_back(t[31:0]);
    ws.push_back(t[63:32]);
  endtask

  task automatic predict_emit(input int unsigned idx);
    logic [31:0] w, rel, head;
    logic [63:0] pc, fend, t, imm, v;
    logic [31:0] ws[$];
    int unsigned ti;
    w = src_words[idx];
    pc = base_addr + 64'(idx) * 4;
    fend = base_addr + 64'(n_loaded) * 4;
    if (op_adr(w) || op_adrp(w)) begin
      imm = sext({43'b0, w[23:5], w[30:29]}, 21);
      t = op_adrp(w) ? (pc & ~64'hFFF) + (imm << 12) : pc + imm;
      ws.push_back(LDR_LIT_X | (32'd2 << 5) | {27'b0, w[4:0]});
      ws.push_back(B_OP | 32'd3);
      ws.push_back(t[31:0]);
      ws.push_back(t[63:32]);
    end else if (op_lit(w)) begin
      v = lit_values[idx];
      if (w[31:30] != 2'b01) v[63:32] = '0;
      ws.push_back((w & IMM19_KEEP) | (32'd2 << 5));
      ws.push_back(B_OP | 32'd3);
      ws.push_back(v[31:0]);
      ws.push_back(v[63:32]);
    end else if (op_bl(w)) begin
      push_far(ws, pc + branch_disp(w), 1'b1);
    end else if (op_b(w) || op_cond(w)) begin
      t = pc + branch_disp(w);
      if (in_extent(t, fend)) begin
        ti = 32'((t - base_addr) >> 2);
        if (ti >= DEPTH) ti = 0;
        rel = {21'b0, clone_offs[ti]} - {21'b0, clone_offs[idx]};
        if (op_b(w)) ws.push_back(B_OP | {6'b0, rel[25:0]});
        else if (op_tbz(w)) ws.push_back((w & IMM14_KEEP) | {13'b0, rel[13:0], 5'b0});
        else ws.push_back((w & IMM19_KEEP) | {8'b0, rel[18:0], 5'b0});
      end else if (op_b(w)) begin
        push_far(ws, t, 1'b0);
      end else begin
        // inverted condition skips over the far jump
        head = op_bcond(w) ? {w[31:4], w[3:0] ^ 4'd1} : w ^ 32'h0100_0000;
        if (op_tbz(w)) ws.push_back((head & IMM14_KEEP) | (32'd5 << 5));
        else ws.push_back((head & IMM19_KEEP) | (32'd5 << 5));
        push_far(ws, t, 1'b0);
      end
    end else begin
      ws.push_back(w);
    end
    foreach (ws[k]) push_word(ws[k], k == ws.size() - 1, ST_OK);
  endtask

  task automatic predict_request(input logic [1:0] f, input logic [31:0] w,
                                 input logic [63:0] lit, input logic [7:0] idx);
    int unsigned slot, lim;
    bit stop;
    logic [63:0] t;
    case (cmd_e'(f))
      CMD_START: begin
        n_loaded = 0;
        extent_end = 1'b0;
        clone_total = '0;
        push_word('0, 1'b1, ST_OK);
      end
      CMD_LOAD: begin
        if (extent_end) begin
          push_word('0, 1'b1, ST_IGN);
        end else begin
          slot = (n_loaded >= DEPTH) ? DEPTH - 1 : n_loaded;
          src_words[slot] = w;
          lit_values[slot] = lit;
          n_loaded = slot + 1;
          lim = eff_limit();
          stop = (w == RET_WORD) || (n_loaded >= lim);
          if (op_b(w)) begin
            t = base_addr + 64'(slot) * 4 + branch_disp(w);
            if (t < base_addr || t >= base_addr + 64'(lim) * 4) stop = 1'b1;
          end
          if (stop) lay_out_clone();
          push_word('0, 1'b1, ST_OK);
        end
      end
      CMD_EMIT: begin
        if (!extent_end) push_word('0, 1'b1, ST_IGN);
        else if (idx >= n_loaded) push_word('0, 1'b1, ST_RANGE);
        else predict_emit(idx);
      end
      default: push_word('0, 1'b1, ST_IGN);
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    clone_word_t e;
    if (!rst_n) begin
      clone_q.delete();
      n_loaded = 0;
      extent_end = 1'b0;
      clone_total = '0;
      base_addr = '0;
      limit_reg = 9'd256;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) base_addr = cfg_wdata;
        else limit_reg = cfg_wdata[8:0];
      end
      if (out_valid && !out_stall) begin
        if (clone_q.size() == 0) begin
          $error("unexpected result: word %0h status %0d", out_output_word, out_status);
          errors++;
        end else begin
          e = clone_q.pop_front();
          check_field("output_word", e.word, out_output_word);
          check_field("last_word", e.last, out_last_word);
          check_field("status", e.st, out_status);
          check_field("extent_done", e.done, out_extent_done);
          check_field("clone_size", e.size, out_clone_size);
          check_field("loaded_count", e.count, out_loaded_count);
        end
      end
      if (in_valid && !in_stall)
        predict_request(in_func, in_instruction_word, in_literal_value, in_emit_index);
    end
    pending = clone_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb import a64rel_pkg::*;;

  typedef enum int {
    K_PLAIN, K_ADR, K_ADRP, K_LIT, K_B_IN, K_BL, K_BC_IN, K_BC_OUT,
    K_CB_IN, K_CB_OUT, K_TB_IN, K_TB_OUT, K_B_OUT, K_RET
  } insn_kind_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [31:0] in_instruction_word;
  logic [63:0] in_literal_value;
  logic [7:0]  in_emit_index;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_output_word;
  logic        out_last_word;
  logic [1:0]  out_status;
  logic        out_extent_done;
  logic [10:0] out_clone_size;
  logic [8:0]  out_loaded_count;

  int fail_count;
  int outstanding;
  int stall_pct;
  int gap_pct;
  bit hold_req;

  aarch64_pc_relative_relocator_core dut (.*);

  relocator_checker checker_i (.*, .errors(fail_count), .pending(outstanding));

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] encode_insn(input insn_kind_e k, input int i, input int len);
    logic [31:0] r, rel;
    r = $urandom;
    rel = 32'($urandom_range(0, len - 1) - i);
    case (k)
      K_ADR:    return (r & ~ADR_MASK) | 32'h1000_0000;
      K_ADRP:   return (r & ~ADR_MASK) | 32'h9000_0000;
      K_LIT:    return (r & ~LIT_MASK) | LIT_MATCH;
      K_B_IN:   return B_OP | {6'b0, rel[25:0]};
      K_B_OUT:  return B_OP | {6'b0, r[25:0]};
      K_BL:     return BL_OP | {6'b0, r[25:0]};
      K_BC_IN:  return BCOND_OP | {8'b0, rel[18:0], 5'b0} | {28'b0, r[3:0]};
      K_BC_OUT: return BCOND_OP | (r & 32'h00FF_FFEF);
      K_CB_IN:  return 32'h3400_0000 | (r & 32'h8100_001F) | {8'b0, rel[18:0], 5'b0};
      K_CB_OUT: return 32'h3400_0000 | (r & 32'h81FF_FFFF);
      K_TB_IN:  return 32'h3600_0000 | (r & 32'h81F8_001F) | {13'b0, rel[13:0], 5'b0};
      K_TB_OUT: return 32'h3600_0000 | (r & 32'h81FF_FFFF);
      K_RET:    return RET_WORD;
      default:  return r;
    endcase
  endfunction

  task automatic issue(input cmd_e f, input logic [31:0] w, input logic [7:0] idx);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_instruction_word <= w;
    in_literal_value <= {$urandom, $urandom};
    in_emit_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic issue_noise();
    issue(cmd_e'($urandom_range(0, 3)), $urandom, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] base, input logic [8:0] lim);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_wdata <= {55'b0, lim};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one function: start, loads ending at RET, then its clone words
  task automatic relocate_function(input int len, input bit directed, input bit noisy);
    insn_kind_e k;
    issue(CMD_START, $urandom, 8'($urandom));
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) issue_noise();
      if (directed) k = insn_kind_e'(i);
      else if (i == len - 1) k = K_RET;
      else k = insn_kind_e'($urandom_range(K_PLAIN, K_B_OUT));
      issue(CMD_LOAD, encode_insn(k, i, len), 8'($urandom));
    end
    if (len > 32) begin
      issue(CMD_EMIT, $urandom, 8'd0);
      issue(CMD_EMIT, $urandom, 8'd255);
      repeat (6) issue(CMD_EMIT, $urandom, 8'($urandom));
    end else begin
      for (int e = 0; e <= len; e++) issue(CMD_EMIT, $urandom, 8'(e));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BASE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_func = CMD_START;
    in_instruction_word = '0;
    in_literal_value = '0;
    in_emit_index = '0;
    stall_pct = 10;
    gap_pct = 10;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset configuration, every kind, ignored and out-of-range cases
    issue(CMD_START, '0, '0);
    issue(CMD_EMIT, '0, 8'd0);
    issue(CMD_BAD, 32'hFFFF_FFFF, 8'hFF);
    relocate_function(14, 1'b1, 1'b0);

    // limit extremes; all-ones base exercises address wrap
    configure(64'hFFFF_FFFF_FFFF_FFFF, 9'd0);
    relocate_function(3, 1'b0, 1'b0);
    configure(64'hFFFF_FFFF_FFFF_FF00, 9'd511);
    relocate_function(12, 1'b0, 1'b0);
    configure({$urandom, $urandom}, 9'd5);
    relocate_function(9, 1'b0, 1'b0);
    configure({$urandom, 20'h0, 12'($urandom_range(0, 4095))}, 9'd256);
    relocate_function(64, 1'b0, 1'b0);

    // the block fills while the receiver holds off
    drain();
    hold_req = 1'b1;
    relocate_function(6, 1'b0, 1'b0);

    for (int n = 0; n < 12; n++) begin
      if (n % 4 == 0)
        configure(($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : 64'h1000,
                  9'($urandom_range(1, 300)));
      if (n >= 9) begin
        stall_pct = 0;
        gap_pct = 0;
      end else begin
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 10;
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 10;
      end
      relocate_function($urandom_range(1, 14), 1'b0, 1'b1);
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/a64rel_pkg.sv
rtl/core/a64rel_ram.sv
rtl/core/a64rel_front.sv
rtl/core/a64rel_back.sv
rtl/core/aarch64_pc_relative_relocator_core.sv
tb/relocator_checker.sv
tb/tb.sv
